FILE: design/hbs_pkg.sv
// Shared types, register map and defaults of the heightmap bilinear sampler.
package hbs_pkg;

	// Defaults of the store geometry parameters
	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_DEPTH = 256;

	// Result queue depth; must exceed the query pipeline length
	localparam int RSP_FIFO_DEPTH = 16;

	// Operation codes
	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_MAP_WIDTH   = 3'd0;
	localparam logic [2:0] REG_MAP_DEPTH   = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Z    = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd4;
	localparam logic [2:0] REG_INV_CELL_X  = 3'd5;
	localparam logic [2:0] REG_INV_CELL_Z  = 3'd6;
	localparam logic [2:0] REG_HEIGHT_GAIN = 3'd7;

	// Register reset values
	localparam logic [8:0]  RST_MAP_WIDTH   = 9'd256;
	localparam logic [8:0]  RST_MAP_DEPTH   = 9'd256;
	localparam logic [31:0] RST_INV_CELL    = 32'd65536;
	localparam logic [31:0] RST_HEIGHT_GAIN = 32'd257;

	// Input item
	typedef struct packed {
		op_t                op;
		logic [15:0]        sample_index;
		logic [7:0]         sample_value;
		logic signed [31:0] world_x;
		logic signed [31:0] world_z;
	} req_item_t;

	// Result item
	typedef struct packed {
		logic signed [31:0] height;
		logic               in_range;
	} rsp_item_t;

endpackage

FILE: design/heightmap_bilinear_sampler_top.sv
// Heightmap store with a pipelined bilinear height query path.
//
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | hbs_pkg::req_item_t (load or query)
// rsp     | out       | rsp_valid, rsp_stall | hbs_pkg::rsp_item_t (one per query)
// apb     | in        | psel, penable, ...   | eight 32-bit registers at 4 * index
//
// One item is accepted per cycle while req_stall is low. A query's result passes
// through stages 1 to 9 and is then written to the queue that drives rsp.
// A load writes the store in stage 3, the same stage that issues the four
// neighbour reads (two store copies, two read ports each).
// Reset clears registers, map_loaded and the queue; the store is not cleared.
// Up to 16 queries may be in flight or queued; req_stall rises only when all are held.
module heightmap_bilinear_sampler_top #(
	parameter int MAX_WIDTH = hbs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_DEPTH = hbs_pkg::DEF_MAX_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  hbs_pkg::req_item_t req_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hbs_pkg::rsp_item_t rsp_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int StoreSize  = MAX_WIDTH * MAX_DEPTH;
	localparam int StoreDepth = (StoreSize > 65536) ? 65536 : StoreSize;
	localparam int Aw         = $clog2(StoreDepth);
	localparam int FifoDepth  = hbs_pkg::RSP_FIFO_DEPTH;
	localparam int PtrW       = $clog2(FifoDepth);
	localparam int CntW       = $clog2(FifoDepth + 1);

	// Configuration registers
	logic [8:0]  map_width_q;
	logic [8:0]  map_depth_q;
	logic [31:0] origin_x_q;
	logic [31:0] origin_z_q;
	logic [31:0] origin_y_q;
	logic [31:0] inv_cell_x_q;
	logic [31:0] inv_cell_z_q;
	logic [31:0] height_gain_q;
	logic        map_loaded_q;

	logic       cfg_we;
	logic [2:0] cfg_idx;

	// Handshakes
	logic req_acc;
	logic rsp_acc;

	// Stage 1: local coordinates
	logic              vld_s1;
	hbs_pkg::op_t      op_s1;
	logic [15:0]       idx_s1;
	logic [7:0]        val_s1;
	logic [32:0]       lx_s1;
	logic [32:0]       lz_s1;

	// Stage 2: grid products
	logic              vld_s2;
	hbs_pkg::op_t      op_s2;
	logic [15:0]       idx_s2;
	logic [7:0]        val_s2;
	logic              negx_s2;
	logic              negz_s2;
	logic [63:0]       prodx_s2;
	logic [63:0]       prodz_s2;

	// Stage 3: cell check and base address
	logic              vld_s3;
	hbs_pkg::op_t      op_s3;
	logic [15:0]       idx_s3;
	logic [7:0]        val_s3;
	logic              ok_s3;
	logic [15:0]       fx_s3;
	logic [15:0]       fz_s3;
	logic [17:0]       base_s3;

	// Stage 4: neighbour samples
	logic              vld_s4;
	logic              ok_s4;
	logic [15:0]       fx_s4;
	logic [15:0]       fz_s4;
	logic [7:0]        h00_s4;
	logic [7:0]        h10_s4;
	logic [7:0]        h01_s4;
	logic [7:0]        h11_s4;

	// Stages 5 to 9: blend and gain (the Y offset is added at the queue write)
	logic              vld_s5;
	logic              ok_s5;
	logic [15:0]       fz_s5;
	logic [23:0]       top_s5;
	logic [23:0]       bot_s5;
	logic              vld_s6;
	logic              ok_s6;
	logic [39:0]       mix_s6;
	logic              vld_s7;
	logic              ok_s7;
	logic [23:0]       mixr_s7;
	logic              vld_s8;
	logic              ok_s8;
	logic [55:0]       prod_s8;
	logic              vld_s9;
	logic              ok_s9;
	logic [39:0]       h_s9;

	// Result queue
	hbs_pkg::rsp_item_t fifo_mem [FifoDepth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    occ_q;
	logic [CntW-1:0]    credit_q;

	// Store copies: row of z0 and row of z0 + 1
	logic [7:0] mem_a [StoreDepth];
	logic [7:0] mem_b [StoreDepth];

	// Combinational signals
	logic [32:0]        lx_c;
	logic [32:0]        lz_c;
	logic [8:0]         w_eff;
	logic [8:0]         d_eff;
	logic               ok_c;
	logic [17:0]        base_c;
	logic               ld_we;
	logic [Aw-1:0]      ra0;
	logic [Aw-1:0]      ra1;
	logic [Aw-1:0]      rb0;
	logic [Aw-1:0]      rb1;
	logic signed [8:0]  dtop;
	logic signed [8:0]  dbot;
	logic signed [16:0] fx_sgn;
	logic signed [16:0] fz_sgn;
	logic signed [25:0] top_c;
	logic signed [25:0] bot_c;
	logic signed [24:0] dmix;
	logic signed [41:0] mix_c;
	logic signed [41:0] sum_c;
	logic [31:0]        sat_c;
	hbs_pkg::rsp_item_t res_c;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	// Register port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		case (cfg_idx)
			hbs_pkg::REG_MAP_WIDTH:   prdata = {23'd0, map_width_q};
			hbs_pkg::REG_MAP_DEPTH:   prdata = {23'd0, map_depth_q};
			hbs_pkg::REG_ORIGIN_X:    prdata = origin_x_q;
			hbs_pkg::REG_ORIGIN_Z:    prdata = origin_z_q;
			hbs_pkg::REG_ORIGIN_Y:    prdata = origin_y_q;
			hbs_pkg::REG_INV_CELL_X:  prdata = inv_cell_x_q;
			hbs_pkg::REG_INV_CELL_Z:  prdata = inv_cell_z_q;
			hbs_pkg::REG_HEIGHT_GAIN: prdata = height_gain_q;
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= hbs_pkg::RST_MAP_WIDTH;
			map_depth_q   <= hbs_pkg::RST_MAP_DEPTH;
			origin_x_q    <= 32'd0;
			origin_z_q    <= 32'd0;
			origin_y_q    <= 32'd0;
			inv_cell_x_q  <= hbs_pkg::RST_INV_CELL;
			inv_cell_z_q  <= hbs_pkg::RST_INV_CELL;
			height_gain_q <= hbs_pkg::RST_HEIGHT_GAIN;
		end else if (cfg_we) begin
			case (cfg_idx)
				hbs_pkg::REG_MAP_WIDTH:   map_width_q   <= pwdata[8:0];
				hbs_pkg::REG_MAP_DEPTH:   map_depth_q   <= pwdata[8:0];
				hbs_pkg::REG_ORIGIN_X:    origin_x_q    <= pwdata;
				hbs_pkg::REG_ORIGIN_Z:    origin_z_q    <= pwdata;
				hbs_pkg::REG_ORIGIN_Y:    origin_y_q    <= pwdata;
				hbs_pkg::REG_INV_CELL_X:  inv_cell_x_q  <= pwdata;
				hbs_pkg::REG_INV_CELL_Z:  inv_cell_z_q  <= pwdata;
				hbs_pkg::REG_HEIGHT_GAIN: height_gain_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Clamp the grid size to the store geometry
	assign w_eff = (int'(map_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : map_width_q;
	assign d_eff = (int'(map_depth_q) > MAX_DEPTH) ? 9'(MAX_DEPTH) : map_depth_q;

	// Subtract the origin on entry
	assign lx_c = {req_data.world_x[31], req_data.world_x} - {origin_x_q[31], origin_x_q};
	assign lz_c = {req_data.world_z[31], req_data.world_z} - {origin_z_q[31], origin_z_q};

	// Check the cell against the grid and form the base index
	assign ok_c = (w_eff >= 9'd2) && (d_eff >= 9'd2) && !negx_s2 && !negz_s2
		&& (prodx_s2[63:32] < (32'(w_eff) - 32'd1))
		&& (prodz_s2[63:32] < (32'(d_eff) - 32'd1));
	assign base_c = (18'(prodz_s2[40:32]) * 18'(w_eff)) + 18'(prodx_s2[40:32]);

	// Store write and neighbour addresses
	assign ld_we = vld_s3 && (op_s3 == hbs_pkg::OP_LOAD) && (32'(idx_s3) < 32'(StoreSize));
	assign ra0   = base_s3[Aw-1:0];
	assign ra1   = Aw'(base_s3 + 18'd1);
	assign rb0   = Aw'(base_s3 + 18'(w_eff));
	assign rb1   = Aw'(base_s3 + 18'(w_eff) + 18'd1);

	// Blend along X
	assign fx_sgn = $signed({1'b0, fx_s4});
	assign dtop   = $signed({1'b0, h10_s4}) - $signed({1'b0, h00_s4});
	assign dbot   = $signed({1'b0, h11_s4}) - $signed({1'b0, h01_s4});
	assign top_c  = $signed({2'b00, h00_s4, 16'd0}) + dtop * fx_sgn;
	assign bot_c  = $signed({2'b00, h01_s4, 16'd0}) + dbot * fx_sgn;

	// Blend along Z
	assign fz_sgn = $signed({1'b0, fz_s5});
	assign dmix   = $signed({1'b0, bot_s5}) - $signed({1'b0, top_s5});
	assign mix_c  = $signed({2'b00, top_s5, 16'd0}) + dmix * fz_sgn;

	// Add the Y origin and saturate high
	assign sum_c = $signed({2'b00, h_s9}) + $signed({{10{origin_y_q[31]}}, origin_y_q});
	assign sat_c = (!sum_c[41] && (sum_c[40:31] != 10'd0)) ? 32'h7FFF_FFFF : sum_c[31:0];
	assign res_c.height   = ok_s9 ? $signed(sat_c) : 32'sd0;
	assign res_c.in_range = ok_s9;

	// Valid bits and map state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			vld_s5       <= 1'b0;
			vld_s6       <= 1'b0;
			vld_s7       <= 1'b0;
			vld_s8       <= 1'b0;
			vld_s9       <= 1'b0;
			map_loaded_q <= 1'b0;
		end else begin
			vld_s1 <= req_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			// drop loads once they have written the store
			vld_s4 <= vld_s3 && (op_s3 == hbs_pkg::OP_QUERY);
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			if (ld_we) begin
				map_loaded_q <= 1'b1;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		op_s1    <= req_data.op;
		idx_s1   <= req_data.sample_index;
		val_s1   <= req_data.sample_value;
		lx_s1    <= lx_c;
		lz_s1    <= lz_c;

		op_s2    <= op_s1;
		idx_s2   <= idx_s1;
		val_s2   <= val_s1;
		// a negative coordinate floors below zero unless the product vanishes
		negx_s2  <= lx_s1[32] && (inv_cell_x_q != 32'd0);
		negz_s2  <= lz_s1[32] && (inv_cell_z_q != 32'd0);
		prodx_s2 <= 64'(lx_s1[31:0]) * 64'(inv_cell_x_q);
		prodz_s2 <= 64'(lz_s1[31:0]) * 64'(inv_cell_z_q);

		op_s3    <= op_s2;
		idx_s3   <= idx_s2;
		val_s3   <= val_s2;
		ok_s3    <= ok_c;
		fx_s3    <= prodx_s2[31:16];
		fz_s3    <= prodz_s2[31:16];
		base_s3  <= base_c;

		// loads ahead of this query have already set the flag
		ok_s4    <= ok_s3 && map_loaded_q;
		fx_s4    <= fx_s3;
		fz_s4    <= fz_s3;

		ok_s5    <= ok_s4;
		fz_s5    <= fz_s4;
		top_s5   <= top_c[23:0];
		bot_s5   <= bot_c[23:0];

		ok_s6    <= ok_s5;
		mix_s6   <= mix_c[39:0];

		ok_s7    <= ok_s6;
		mixr_s7  <= 24'((mix_s6 + 40'h8000) >> 16);

		ok_s8    <= ok_s7;
		prod_s8  <= 56'(mixr_s7) * 56'(height_gain_q);

		ok_s9    <= ok_s8;
		h_s9     <= 40'((prod_s8 + 56'h8000) >> 16);
	end

	// Store copy for the near row: write loads, read two neighbours
	always_ff @(posedge clk) begin
		if (ld_we) begin
			mem_a[idx_s3[Aw-1:0]] <= val_s3;
		end
		h00_s4 <= mem_a[ra0];
		h10_s4 <= mem_a[ra1];
	end

	// Store copy for the far row
	always_ff @(posedge clk) begin
		if (ld_we) begin
			mem_b[idx_s3[Aw-1:0]] <= val_s3;
		end
		h01_s4 <= mem_b[rb0];
		h11_s4 <= mem_b[rb1];
	end

	// Result queue and query credits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			credit_q <= '0;
		end else begin
			if (vld_s9) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (rsp_acc) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			occ_q <= occ_q + CntW'(vld_s9) - CntW'(rsp_acc);
			credit_q <= credit_q
				+ CntW'(req_acc && (req_data.op == hbs_pkg::OP_QUERY))
				- CntW'(rsp_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s9) begin
			fifo_mem[wr_ptr_q] <= res_c;
		end
	end

	// Hold input while every queue slot is claimed by a query
	assign req_stall = (credit_q == CntW'(FifoDepth));
	assign rsp_valid = (occ_q != '0);
	assign rsp_data  = fifo_mem[rd_ptr_q];

endmodule
